// File: rtl/core/lspm_pkg.sv
package lspm_pkg;

   localparam int NUM_SEGMENTS   = 4;
   localparam int LED_INDEX_BITS = 12;
   localparam int SEG_WORD_REGS  = 4;

   localparam int SEG_W   = 2 * LED_INDEX_BITS + 9;
   localparam int LEN_W   = LED_INDEX_BITS + 1;
   localparam int SUM_W   = LED_INDEX_BITS + 1 + $clog2(NUM_SEGMENTS);
   localparam int IDX_W   = 14;
   localparam int CMP_W   = (SUM_W > IDX_W) ? SUM_W : IDX_W;
   localparam int QUOT_W  = 8;
   localparam int RW      = CMP_W + QUOT_W;
   localparam int COLOR_W = 8;
   localparam int PROD_W  = 2 * COLOR_W;
   localparam int PHYS_W  = 12;
   localparam int WORD_W  = 3 * COLOR_W;
   localparam int COUNT_W = 3;

   localparam int REQ_TDATA_W = ((IDX_W + 4 * COLOR_W) + 7) / 8 * 8;
   localparam int RSP_TDATA_W = ((PHYS_W + WORD_W) + 7) / 8 * 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = SEG_W;

   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SEGMENT_A     = 3'd1;

   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   localparam logic [COLOR_W-1:0] COLOR_FULL      = 8'd255;
   localparam logic [COLOR_W-1:0] WHEEL_THIRD     = 8'd85;
   localparam logic [COLOR_W-1:0] WHEEL_TWO_THIRD = 8'd170;
   localparam logic [COLOR_W+1:0] WHEEL_STEP      = 10'd3;

   typedef struct packed {
      logic [NUM_SEGMENTS-1:0][LED_INDEX_BITS-1:0] first;
      logic [NUM_SEGMENTS-1:0]                     fwd;
      logic [NUM_SEGMENTS-1:0]                     chan;
      logic [NUM_SEGMENTS-1:0][COLOR_W-1:0]        bri;
      logic [NUM_SEGMENTS-1:0][SUM_W-1:0]          seg_start;
      logic [NUM_SEGMENTS-1:0][SUM_W-1:0]          seg_end;
      logic [NUM_SEGMENTS-1:0]                     used;
      logic [SUM_W-1:0]                            divisor;
      logic                                        single;
      logic                                        settled;
   } cfg_type;

   typedef struct packed {
      logic                      hit;
      logic                      func;
      logic                      chan;
      logic                      fwd;
      logic [IDX_W-1:0]          idx;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
      logic [COLOR_W-1:0]        offs;
      logic [COLOR_W-1:0]        bri;
      logic [LED_INDEX_BITS-1:0] first;
      logic [LED_INDEX_BITS-1:0] rem;
      logic [LED_INDEX_BITS-1:0] phys;
      logic [RW-1:0]             drem;
      logic [QUOT_W-1:0]         quot;
      logic [PROD_W-1:0]         prod_r;
      logic [PROD_W-1:0]         prod_g;
      logic [PROD_W-1:0]         prod_b;
      logic [WORD_W-1:0]         color;
   } item_type;

endpackage

// File: rtl/core/lspm_cfg.sv
module lspm_cfg import lspm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [COUNT_W-1:0]                   count_ff;
   logic [NUM_SEGMENTS-1:0][SEG_W-1:0]   word_ff;
   logic [NUM_SEGMENTS-1:0][LEN_W-1:0]   len_ff, len_in;
   logic [NUM_SEGMENTS-1:0]              used_ff, used_in;
   logic [NUM_SEGMENTS-1:0][SUM_W-1:0]   start_ff, start_in;
   logic [NUM_SEGMENTS-1:0][SUM_W-1:0]   end_ff, end_in;
   logic [SUM_W-1:0]                     total_ff, total_in;
   logic [SUM_W-1:0]                     divisor_ff;
   logic                                 single_ff;
   logic [1:0]                           settle_ff;
   logic [COUNT_W-1:0]                   n_sat;
   logic [LED_INDEX_BITS-1:0]            f, l;
   logic [SUM_W-1:0]                     acc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         word_ff   <= '0;
         settle_ff <= SETTLE_CYCLES;
      end else begin
         if (csr_valid && csr_ready) begin
            settle_ff <= SETTLE_CYCLES;
            if (csr_index == REG_SEGMENT_COUNT) begin
               count_ff <= csr_data[COUNT_W-1:0];
            end
            for (int s = 0; s < NUM_SEGMENTS; s++) begin
               if (s < SEG_WORD_REGS && csr_index == CSR_IDX_W'(int'(REG_SEGMENT_A) + s)) begin
                  word_ff[s] <= csr_data[SEG_W-1:0];
               end
            end
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_comb begin
      n_sat = (count_ff > COUNT_W'(NUM_SEGMENTS)) ? COUNT_W'(NUM_SEGMENTS) : count_ff;
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         f = word_ff[s][LED_INDEX_BITS-1:0];
         l = word_ff[s][2*LED_INDEX_BITS-1:LED_INDEX_BITS];
         len_in[s]  = (f > l) ? LEN_W'(f - l) + LEN_W'(1) : LEN_W'(l - f) + LEN_W'(1);
         used_in[s] = COUNT_W'(s) < n_sat;
         cfg.first[s] = f;
         cfg.fwd[s]   = f < l;
         cfg.chan[s]  = word_ff[s][2*LED_INDEX_BITS];
         cfg.bri[s]   = word_ff[s][2*LED_INDEX_BITS+COLOR_W:2*LED_INDEX_BITS+1];
      end
      cfg.seg_start = start_ff;
      cfg.seg_end   = end_ff;
      cfg.used      = used_ff;
      cfg.divisor   = divisor_ff;
      cfg.single    = single_ff;
      cfg.settled   = settle_ff == 2'd0;
   end

   always_comb begin
      acc = '0;
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         start_in[s] = acc;
         acc = acc + SUM_W'(len_ff[s]);
         end_in[s] = acc;
      end
      total_in = '0;
      for (int s = 0; s < NUM_SEGMENTS; s++) begin
         if (used_ff[s]) begin
            total_in = end_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff     <= len_in;
      used_ff    <= used_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      total_ff   <= total_in;
      divisor_ff <= total_ff - SUM_W'(1);
      single_ff  <= total_ff <= SUM_W'(1);
   end

endmodule

// File: rtl/core/lspm_locate.sv
module lspm_locate import lspm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff, adv;
   item_type          stage_ff [STAGES];
   item_type          stage_in [STAGES];

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_item  = stage_ff[STAGES-1];

   always_comb begin
      stage_in[0] = in_item;

      stage_in[1]     = stage_ff[0];
      stage_in[1].hit = 1'b0;
      for (int s = NUM_SEGMENTS - 1; s >= 0; s--) begin
         if (cfg.used[s] && CMP_W'(stage_ff[0].idx) < CMP_W'(cfg.seg_end[s])) begin
            stage_in[1].hit   = 1'b1;
            stage_in[1].first = cfg.first[s];
            stage_in[1].fwd   = cfg.fwd[s];
            stage_in[1].chan  = cfg.chan[s];
            stage_in[1].bri   = cfg.bri[s];
            stage_in[1].rem   = LED_INDEX_BITS'(CMP_W'(stage_ff[0].idx)
                                                - CMP_W'(cfg.seg_start[s]));
         end
      end

      stage_in[2]      = stage_ff[1];
      stage_in[2].phys = stage_ff[1].fwd ? stage_ff[1].first + stage_ff[1].rem
                                         : stage_ff[1].first - stage_ff[1].rem;
      stage_in[2].drem = (RW'(stage_ff[1].idx) << QUOT_W) - RW'(stage_ff[1].idx);
      stage_in[2].quot = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_phys_in_segment: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] && stage_ff[2].hit |->
         (stage_ff[2].fwd ? stage_ff[2].phys >= stage_ff[2].first
                          : stage_ff[2].phys <= stage_ff[2].first))
      else $error("physical index left its segment");
`endif

endmodule

// File: rtl/core/lspm_div.sv
module lspm_div import lspm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int STAGES = QUOT_W;

   logic [STAGES-1:0] valid_ff, adv;
   item_type          stage_ff [STAGES];
   item_type          stage_in [STAGES];
   item_type          src      [STAGES];

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_item  = stage_ff[STAGES-1];

   always_comb begin
      logic [RW-1:0] shifted;
      logic [RW:0]   trial;
      src[0] = in_item;
      for (int j = 1; j < STAGES; j++) begin
         src[j] = stage_ff[j-1];
      end
      for (int j = 0; j < STAGES; j++) begin
         shifted     = RW'(cfg.divisor) << (STAGES - 1 - j);
         trial       = {1'b0, src[j].drem} - {1'b0, shifted};
         stage_in[j] = src[j];
         if (!trial[RW]) begin
            stage_in[j].drem                = trial[RW-1:0];
            stage_in[j].quot[STAGES-1-j]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && stage_ff[STAGES-1].hit && !cfg.single |->
         stage_ff[STAGES-1].drem < RW'(cfg.divisor))
      else $error("wheel division left a remainder not below the divisor");
`endif

endmodule

// File: rtl/core/lspm_color.sv
module lspm_color import lspm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int STAGES = 3;

   logic [STAGES-1:0] valid_ff, adv;
   item_type          stage_ff [STAGES];
   item_type          stage_in [STAGES];

   function automatic logic [COLOR_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] sum;
      sum = PROD_W'(x) + (PROD_W+1)'(x >> COLOR_W) + (PROD_W+1)'(1);
      return COLOR_W'(sum >> COLOR_W);
   endfunction

   always_comb begin
      adv[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[STAGES-1];
   assign out_item  = stage_ff[STAGES-1];

   always_comb begin
      logic [COLOR_W-1:0]   pos, p;
      logic [COLOR_W+1:0]   p3;
      logic [COLOR_W-1:0]   wr, wg, wb;
      pos = cfg.single ? in_item.offs : in_item.quot + in_item.offs;
      if (pos < WHEEL_THIRD) begin
         p = pos;
      end else if (pos < WHEEL_TWO_THIRD) begin
         p = pos - WHEEL_THIRD;
      end else begin
         p = pos - WHEEL_TWO_THIRD;
      end
      p3 = (COLOR_W+2)'(p) * WHEEL_STEP;
      if (pos < WHEEL_THIRD) begin
         wr = COLOR_W'(p3);
         wg = COLOR_FULL - COLOR_W'(p3);
         wb = '0;
      end else if (pos < WHEEL_TWO_THIRD) begin
         wr = COLOR_FULL - COLOR_W'(p3);
         wg = '0;
         wb = COLOR_W'(p3);
      end else begin
         wr = '0;
         wg = COLOR_W'(p3);
         wb = COLOR_FULL - COLOR_W'(p3);
      end
      stage_in[0] = in_item;
      if (in_item.func) begin
         stage_in[0].red   = wr;
         stage_in[0].green = wg;
         stage_in[0].blue  = wb;
      end

      stage_in[1]        = stage_ff[0];
      stage_in[1].prod_r = PROD_W'(stage_ff[0].bri) * PROD_W'(stage_ff[0].red);
      stage_in[1].prod_g = PROD_W'(stage_ff[0].bri) * PROD_W'(stage_ff[0].green);
      stage_in[1].prod_b = PROD_W'(stage_ff[0].bri) * PROD_W'(stage_ff[0].blue);

      stage_in[2]       = stage_ff[1];
      stage_in[2].color = {div255(stage_ff[1].prod_r), div255(stage_ff[1].prod_g),
                           div255(stage_ff[1].prod_b)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            valid_ff[1] <= valid_ff[0];
         end
         if (adv[2]) begin
            valid_ff[2] <= valid_ff[1] && stage_ff[1].hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

endmodule

// File: rtl/core/led_segment_pixel_mapper.sv
// LED segment pixel mapper.
// Input channel req_: one pixel write per item, addressed by a logical LED
// index over the chained segments; req_tuser picks direct RGB or wheel color.
// Result channel rsp_: channel, physical LED index and packed scaled color.
// A write whose index lies past the chain yields no result item.
// Configuration channel csr_: register index and data, always ready; after a
// write req_tready stays low while segment ends and the wheel divisor are
// rebuilt.
// The 14-stage pipeline has 3 locate stages, 8 stages of a bit-per-stage
// restoring divider and 3 color stages; one item is accepted per cycle
// while the receiver keeps up and no configuration write is settling.
// A receiver stall fills the pipeline stage by stage; empty stages keep
// taking items until the stall reaches the input, nothing is dropped.
// Reset is synchronous: it empties the pipeline, clears the segment count and
// segment words, and holds req_tready low while the configuration settles.
module led_segment_pixel_mapper import lspm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // led_index, red, green, blue, wheel_offset
   input  logic                   req_tuser,  // func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // physical_index, color_word
   output logic                   rsp_tuser,  // strip_channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg;
   item_type in_item, loc_item, div_item, col_item;
   logic     loc_in_ready, loc_valid, div_ready, div_valid, col_ready;

   lspm_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_comb begin
      in_item       = '0;
      in_item.func  = req_tuser;
      in_item.idx   = req_tdata[IDX_W-1:0];
      in_item.red   = req_tdata[IDX_W+COLOR_W-1:IDX_W];
      in_item.green = req_tdata[IDX_W+2*COLOR_W-1:IDX_W+COLOR_W];
      in_item.blue  = req_tdata[IDX_W+3*COLOR_W-1:IDX_W+2*COLOR_W];
      in_item.offs  = req_tdata[IDX_W+4*COLOR_W-1:IDX_W+3*COLOR_W];
   end

   assign req_tready = loc_in_ready && cfg.settled;

   lspm_locate u_locate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid && cfg.settled),
      .in_ready  (loc_in_ready),
      .in_item   (in_item),
      .out_valid (loc_valid),
      .out_ready (div_ready),
      .out_item  (loc_item)
   );

   lspm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (loc_valid),
      .in_ready  (div_ready),
      .in_item   (loc_item),
      .out_valid (div_valid),
      .out_ready (col_ready),
      .out_item  (div_item)
   );

   lspm_color u_color (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (div_valid),
      .in_ready  (col_ready),
      .in_item   (div_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (col_item)
   );

   assign rsp_tdata = RSP_TDATA_W'({col_item.color, PHYS_W'(col_item.phys)});
   assign rsp_tuser = col_item.chan;

`ifndef NO_ASSERTIONS
   a_settle_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("item taken right after a configuration write");
`endif

endmodule

// File: test/lspm_pixel_checker.sv
module lspm_pixel_checker import lspm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // led_index, red, green, blue, wheel_offset
   input  logic                   req_tuser,  // func
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // physical_index, color_word
   input  logic                   rsp_tuser,  // strip_channel
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     errors,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              chan;
      logic [PHYS_W-1:0] phys;
      logic [WORD_W-1:0] color;
   } led_write_type;

   logic [COUNT_W-1:0] seg_count;
   logic [SEG_W-1:0]   seg_word [SEG_WORD_REGS];
   led_write_type      due_writes [$];

   function automatic int unsigned seg_span(input logic [SEG_W-1:0] w);
      int unsigned f;
      int unsigned l;
      f = w[LED_INDEX_BITS-1:0];
      l = w[2*LED_INDEX_BITS-1:LED_INDEX_BITS];
      return (f > l) ? f - l + 1 : l - f + 1;
   endfunction

   function automatic logic map_pixel(input logic wheel_mode, input logic [IDX_W-1:0] idx,
                                      input logic [COLOR_W-1:0] red, green, blue, offs,
                                      output led_write_type wr);
      int unsigned n, total, rem, f, l, bri, pos, r, g, b;
      logic hit;
      n = (seg_count > NUM_SEGMENTS) ? NUM_SEGMENTS : seg_count;
      total = 0;
      rem = idx;
      hit = 1'b0;
      wr = '0;
      for (int s = 0; s < n; s++) total += seg_span(seg_word[s]);
      for (int s = 0; s < n; s++) begin
         if (!hit && rem < seg_span(seg_word[s])) begin
            hit = 1'b1;
            f = seg_word[s][LED_INDEX_BITS-1:0];
            l = seg_word[s][2*LED_INDEX_BITS-1:LED_INDEX_BITS];
            bri = seg_word[s][SEG_W-1 -: COLOR_W];
            r = red;
            g = green;
            b = blue;
            if (wheel_mode) begin
               pos = offs;
               if (total > 1) pos = (int'(COLOR_FULL) * idx) / (total - 1) + offs;
               pos = pos & 32'hff;
               if (pos < WHEEL_THIRD) begin
                  r = pos * WHEEL_STEP;
                  g = COLOR_FULL - pos * WHEEL_STEP;
                  b = 0;
               end else if (pos < WHEEL_TWO_THIRD) begin
                  pos = pos - WHEEL_THIRD;
                  r = COLOR_FULL - pos * WHEEL_STEP;
                  g = 0;
                  b = pos * WHEEL_STEP;
               end else begin
                  pos = pos - WHEEL_TWO_THIRD;
                  r = 0;
                  g = pos * WHEEL_STEP;
                  b = COLOR_FULL - pos * WHEEL_STEP;
               end
            end
            wr.chan = seg_word[s][2*LED_INDEX_BITS];
            wr.phys = PHYS_W'((f < l) ? f + rem : f - rem);
            wr.color = {COLOR_W'(bri * r / COLOR_FULL), COLOR_W'(bri * g / COLOR_FULL),
                        COLOR_W'(bri * b / COLOR_FULL)};
         end else if (!hit) begin
            rem = rem - seg_span(seg_word[s]);
         end
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
      errors++;
   endtask

   always @(posedge clock) begin
      led_write_type got;
      led_write_type want;
      led_write_type due;
      if (reset) begin
         seg_count <= '0;
         foreach (seg_word[s]) seg_word[s] <= '0;
         due_writes.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_SEGMENT_COUNT) begin
               seg_count <= csr_data[COUNT_W-1:0];
            end else if (csr_index >= REG_SEGMENT_A &&
                         csr_index < REG_SEGMENT_A + SEG_WORD_REGS) begin
               seg_word[2'(csr_index - REG_SEGMENT_A)] <= csr_data;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[PHYS_W-1:0], rsp_tdata[PHYS_W +: WORD_W]};
            if (due_writes.size() == 0) begin
               report_mismatch("item with none expected", 32'(got.color), '0);
            end else begin
               want = due_writes.pop_front();
               if (got.chan != want.chan) report_mismatch("strip_channel", got.chan, want.chan);
               if (got.phys != want.phys) report_mismatch("physical_index", got.phys, want.phys);
               if (got.color != want.color) report_mismatch("color_word", got.color, want.color);
            end
         end
         if (req_tvalid && req_tready &&
             map_pixel(req_tuser, req_tdata[IDX_W-1:0], req_tdata[IDX_W +: COLOR_W],
                       req_tdata[IDX_W+COLOR_W +: COLOR_W],
                       req_tdata[IDX_W+2*COLOR_W +: COLOR_W],
                       req_tdata[IDX_W+3*COLOR_W +: COLOR_W], due)) begin
            due_writes.insert(due_writes.size(), due);
         end
         pending <= due_writes.size();
      end
   end

endmodule

// File: test/tb_led_segment_pixel_mapper.sv
module tb_led_segment_pixel_mapper;
   timeunit 1ns;
   timeprecision 1ps;
   import lspm_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 120000;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          STALL_CYCLES = 400;
   localparam int          PHASES       = 9;
   localparam int          PHASE_ITEMS  = 175;
   localparam int          LED_MAX      = (1 << LED_INDEX_BITS) - 1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     errors;
   int                     pending;

   logic [COUNT_W-1:0] used_count = '0;
   int unsigned        seg_len [SEG_WORD_REGS] = '{default: 1};
   int                 tx_idle_pct;
   int                 rx_idle_pct;
   int                 hold_left = 0;
   int unsigned        cycle_count = 0;

   led_segment_pixel_mapper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lspm_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // hold off for a counted stretch when asked, else stall at random
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic logic [SEG_W-1:0] make_word(input int unsigned first, last,
                                                  input logic chan,
                                                  input logic [COLOR_W-1:0] bri);
      return {bri, chan, LED_INDEX_BITS'(last), LED_INDEX_BITS'(first)};
   endfunction

   function automatic int unsigned active_segments();
      return (used_count > NUM_SEGMENTS) ? NUM_SEGMENTS : used_count;
   endfunction

   function automatic int unsigned chain_start(input int unsigned upto);
      int unsigned sum;
      sum = 0;
      for (int s = 0; s < upto; s++) sum += seg_len[s];
      return sum;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      int unsigned f;
      int unsigned l;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == REG_SEGMENT_COUNT) begin
         used_count = data[COUNT_W-1:0];
      end else if (idx >= REG_SEGMENT_A && idx < REG_SEGMENT_A + SEG_WORD_REGS) begin
         f = data[LED_INDEX_BITS-1:0];
         l = data[2*LED_INDEX_BITS-1:LED_INDEX_BITS];
         seg_len[2'(idx - REG_SEGMENT_A)] = (f > l) ? f - l + 1 : l - f + 1;
      end
      @(negedge clock);
   endtask

   // drain the pipeline, including writes past the chain that give no item
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_chain(input logic [COUNT_W-1:0] count,
                             input logic [SEG_WORD_REGS-1:0][SEG_W-1:0] words);
      quiesce();
      csr_write(REG_SEGMENT_COUNT, CSR_DATA_W'(count));
      for (int s = 0; s < SEG_WORD_REGS; s++) begin
         csr_write(CSR_IDX_W'(int'(REG_SEGMENT_A) + s), words[s]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic push_pixel(input logic wheel_mode, input logic [IDX_W-1:0] idx,
                             input logic [COLOR_W-1:0] red, green, blue, offs);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= wheel_mode;
      req_tdata  <= {2'b00, offs, blue, green, red, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_pixel();
      int unsigned n, total, s, pick;
      logic [IDX_W-1:0] idx;
      n = active_segments();
      total = chain_start(n);
      pick = $urandom_range(9);
      if (total == 0 || pick == 0) begin
         idx = IDX_W'($urandom());
      end else if (pick == 1) begin
         idx = IDX_W'(total + $urandom_range(2));
      end else if (pick == 2) begin
         s = $urandom_range(n - 1);
         idx = IDX_W'(chain_start(s) + ($urandom_range(1) ? 0 : seg_len[s] - 1));
      end else begin
         idx = IDX_W'($urandom_range(total - 1));
      end
      push_pixel(1'($urandom_range(1)), idx, COLOR_W'($urandom()), COLOR_W'($urandom()),
                 COLOR_W'($urandom()), COLOR_W'($urandom()));
   endtask

   task automatic random_chain(input bit full);
      logic [SEG_WORD_REGS-1:0][SEG_W-1:0] words;
      logic [COUNT_W-1:0] count;
      logic [COLOR_W-1:0] bri;
      int unsigned first, last, span, pick;
      for (int s = 0; s < SEG_WORD_REGS; s++) begin
         pick = $urandom_range(3);
         first = $urandom_range(LED_MAX);
         span = (pick == 3) ? 0 : $urandom_range(15);
         if ($urandom_range(1)) last = (first + span > LED_MAX) ? LED_MAX : first + span;
         else last = (first >= span) ? first - span : 0;
         case ($urandom_range(7))
            0: bri = '0;
            1: bri = COLOR_FULL;
            default: bri = COLOR_W'($urandom());
         endcase
         words[s] = make_word(first, last, 1'($urandom_range(1)), bri);
         if (pick == 0) words[s] = {1'($urandom_range(1)), $urandom()};
      end
      pick = $urandom_range(9);
      if (full) count = COUNT_W'(NUM_SEGMENTS);
      else if (pick == 0) count = '0;
      else if (pick == 1) count = COUNT_W'($urandom_range(7, NUM_SEGMENTS + 1));
      else count = COUNT_W'($urandom_range(NUM_SEGMENTS, 1));
      load_chain(count, words);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      tx_idle_pct = 38;
      rx_idle_pct = 73;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty chain after reset
      push_pixel(1'b0, 14'd0, 8'hff, 8'hff, 8'hff, 8'h00);
      push_pixel(1'b1, 14'd5, 8'h00, 8'h00, 8'h00, 8'hff);

      // forward, reversed, one-LED and dark segments
      load_chain(3'd4, {make_word(4000, LED_MAX, 1'b0, COLOR_FULL),
                        make_word(100, 100, 1'b1, 8'd0),
                        make_word(LED_MAX, LED_MAX - 5, 1'b1, 8'd128),
                        make_word(0, 9, 1'b0, COLOR_FULL)});
      push_pixel(1'b0, 14'd0, 8'hff, 8'hff, 8'hff, 8'h00);
      push_pixel(1'b0, 14'd9, 8'h00, 8'h00, 8'h00, 8'h00);
      push_pixel(1'b0, 14'd10, 8'hff, 8'h80, 8'h01, 8'h00);
      push_pixel(1'b0, 14'd15, 8'h12, 8'h34, 8'h56, 8'h00);
      push_pixel(1'b0, 14'd16, 8'hff, 8'hff, 8'hff, 8'h00);
      push_pixel(1'b0, 14'd112, 8'hff, 8'hff, 8'hff, 8'h00);
      push_pixel(1'b0, 14'd113, 8'hff, 8'hff, 8'hff, 8'h00);
      push_pixel(1'b1, 14'd0, 8'h00, 8'h00, 8'h00, 8'd0);
      push_pixel(1'b1, 14'd112, 8'h00, 8'h00, 8'h00, 8'd255);
      push_pixel(1'b1, 14'd37, 8'hff, 8'hff, 8'hff, 8'd0);
      push_pixel(1'b1, 14'd0, 8'h00, 8'h00, 8'h00, 8'd85);
      push_pixel(1'b1, 14'd0, 8'h00, 8'h00, 8'h00, 8'd169);
      push_pixel(1'b1, 14'd0, 8'h00, 8'h00, 8'h00, 8'd170);
      push_pixel(1'b1, 14'h3fff, 8'hff, 8'hff, 8'hff, 8'hff);

      // longest chain, count above the segment limit
      load_chain(3'd7, {make_word(LED_MAX, 0, 1'b1, COLOR_FULL),
                        make_word(0, LED_MAX, 1'b1, COLOR_FULL),
                        make_word(0, LED_MAX, 1'b1, COLOR_FULL),
                        make_word(0, LED_MAX, 1'b1, COLOR_FULL)});
      csr_write(REG_UNUSED, '1);
      csr_valid <= 1'b0;
      push_pixel(1'b1, 14'h3fff, 8'h00, 8'h00, 8'h00, 8'd0);
      push_pixel(1'b0, 14'h3fff, 8'hff, 8'hff, 8'hff, 8'd0);
      push_pixel(1'b1, 14'd8191, 8'h00, 8'h00, 8'h00, 8'd128);

      // single LED in the chain: wheel position is the offset alone
      load_chain(3'd1, {4{{CSR_DATA_W{1'b1}}}});
      push_pixel(1'b1, 14'd0, 8'h00, 8'h00, 8'h00, 8'd84);
      push_pixel(1'b1, 14'd0, 8'h00, 8'h00, 8'h00, 8'd255);
      push_pixel(1'b1, 14'd1, 8'h00, 8'h00, 8'h00, 8'd0);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < PHASES / 3) begin
            tx_idle_pct = 38;
            rx_idle_pct = 73;
         end else if (ph < 2 * PHASES / 3) begin
            tx_idle_pct = 73;
            rx_idle_pct = 38;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         random_chain(ph == 2 * PHASES / 3);
         if (ph == 2 * PHASES / 3) hold_left = STALL_CYCLES;
         repeat (PHASE_ITEMS) random_pixel();
      end

      quiesce();
      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/lspm_pkg.sv
rtl/core/lspm_cfg.sv
rtl/core/lspm_locate.sv
rtl/core/lspm_div.sv
rtl/core/lspm_color.sv
rtl/core/led_segment_pixel_mapper.sv
test/lspm_pixel_checker.sv
test/tb_led_segment_pixel_mapper.sv
